[src/oess_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// oess_pkg
// shared types, constants and ordering function for the odd/even split sorter
// ----------------------------------------------------------------------------
package oess_pkg;

    localparam int DATA_W = 32;

    typedef logic [DATA_W-1:0] data_t;

    // controller states
    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } state_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic insert;
        logic shift_out;
    } cell_ctrl_t;

    // true when a is placed ahead of b: odd values ascending, then even descending
    function automatic logic goes_before(input data_t a, input data_t b);
        logic res;
        if (a[0] != b[0])
        begin
            res = a[0];
        end
        else if (a[0])
        begin
            res = $signed(a) < $signed(b);
        end
        else
        begin
            res = $signed(a) > $signed(b);
        end
        return res;
    endfunction

endpackage
`default_nettype wire

[src/odd_even_split_sorter_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// odd_even_split_sorter_unit
// collects a list of signed values and returns it with odd values ascending
// followed by even values descending
// ----------------------------------------------------------------------------
// Each input value is dropped into its sorted place in a chain of
// MAX_ELEMENTS compare cells as it arrives, so busy stays low while a list
// is loading. After the transfer that carries last_item, busy rises and the
// chain drains out of its head cell at one result per cycle; start is
// ignored until the final result has gone out. Results appear for exactly
// one cycle with strobe high and cannot be held off by the receiver. Values
// past MAX_ELEMENTS are dropped, and overflow is then high on every result
// of that list.
// ----------------------------------------------------------------------------
module odd_even_split_sorter_unit #(
    parameter int MAX_ELEMENTS = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] value,
    input  wire logic        last_item,
    output logic             strobe,
    output logic [31:0]      sorted_value,
    output logic             last_result,
    output logic             overflow
);

    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ELEMENTS);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    oess_pkg::state_t   state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               flag_reg, flag_next;
    oess_pkg::cell_ctrl_t ctrl;

    logic               accept;
    logic               has_room;

    // chain wiring
    logic               cell_ins   [MAX_ELEMENTS];
    oess_pkg::data_t    cell_value [MAX_ELEMENTS];
    logic               cell_valid [MAX_ELEMENTS];

    assign accept   = start && !busy;
    assign has_room = count_reg < CNT_MAX;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            oess_pkg::ST_LOAD:
            begin
                if (accept && last_item)
                begin
                    state_next = oess_pkg::ST_DRAIN;
                end
            end
            oess_pkg::ST_DRAIN:
            begin
                if (count_reg <= CNT_ONE)
                begin
                    state_next = oess_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = oess_pkg::ST_LOAD;
            end
        endcase
    end

    // outputs and datapath control
    always_comb
    begin
        busy       = 1'b0;
        strobe     = 1'b0;
        ctrl       = '0;
        count_next = count_reg;
        flag_next  = flag_reg;
        unique case (state_reg)
            oess_pkg::ST_LOAD:
            begin
                if (accept)
                begin
                    if (has_room)
                    begin
                        ctrl.insert = 1'b1;
                        count_next  = count_reg + CNT_ONE;
                    end
                    else
                    begin
                        // store full: drop the value and remember the loss
                        flag_next = 1'b1;
                    end
                end
            end
            oess_pkg::ST_DRAIN:
            begin
                busy           = 1'b1;
                strobe         = 1'b1;
                ctrl.shift_out = 1'b1;
                count_next     = count_reg - CNT_ONE;
                if (count_reg <= CNT_ONE)
                begin
                    // list done, clear for the next one
                    count_next = '0;
                    flag_next  = 1'b0;
                end
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= oess_pkg::ST_LOAD;
            count_reg <= '0;
            flag_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            flag_reg  <= flag_next;
        end
    end

    // the chain of compare cells, head cell first
    for (genvar i = 0; i < MAX_ELEMENTS; i++)
    begin : g_cell
        logic            p_ins;
        oess_pkg::data_t p_value;
        logic            p_valid;
        oess_pkg::data_t n_value;
        logic            n_valid;

        if (i == 0)
        begin : g_head
            assign p_ins   = 1'b0;
            assign p_value = '0;
            assign p_valid = 1'b0;
        end
        else
        begin : g_body
            assign p_ins   = cell_ins[i-1];
            assign p_value = cell_value[i-1];
            assign p_valid = cell_valid[i-1];
        end

        if (i == MAX_ELEMENTS - 1)
        begin : g_tail
            assign n_value = '0;
            assign n_valid = 1'b0;
        end
        else
        begin : g_inner
            assign n_value = cell_value[i+1];
            assign n_valid = cell_valid[i+1];
        end

        oess_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .new_value  (value),
            .prev_ins   (p_ins),
            .prev_value (p_value),
            .prev_valid (p_valid),
            .next_value (n_value),
            .next_valid (n_valid),
            .ins        (cell_ins[i]),
            .value_q    (cell_value[i]),
            .valid_q    (cell_valid[i])
        );
    end

    // results come straight out of the head cell
    assign sorted_value = cell_value[0];
    assign last_result  = strobe && (count_reg == CNT_ONE);
    assign overflow     = flag_reg;

    // a result is only shown while the head cell holds a stored value
    a_strobe_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> cell_valid[0])
        else $error("result strobed from an empty head cell");

    // the final result returns the block to loading
    a_last_ends_drain: assert property (@(posedge clk) disable iff (!rst_n)
        last_result |=> !busy && (count_reg == '0) && !flag_reg)
        else $error("block still busy after the final result");

    // stored count never exceeds the chain length
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX)
        else $error("element count beyond chain length");

    // a list that ends starts draining at once, with at least one value
    a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_item) |=> strobe && (count_reg != '0))
        else $error("drain did not start after the last item");

endmodule
`default_nettype wire

[src/oess_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// oess_cell
// one slot of the insertion chain: holds one value, compares against the
// broadcast value, shifts right on insert and left on drain
// ----------------------------------------------------------------------------
module oess_cell (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire oess_pkg::cell_ctrl_t ctrl,
    input  wire oess_pkg::data_t      new_value,
    input  wire logic                 prev_ins,
    input  wire oess_pkg::data_t      prev_value,
    input  wire logic                 prev_valid,
    input  wire oess_pkg::data_t      next_value,
    input  wire logic                 next_valid,
    output logic                      ins,
    output oess_pkg::data_t           value_q,
    output logic                      valid_q
);

    oess_pkg::data_t val_reg, val_next;
    logic            vld_reg, vld_next;

    // empty slots always accept, so the insert flags form a 0..01..1 pattern
    assign ins = !vld_reg || oess_pkg::goes_before(new_value, val_reg);

    always_comb
    begin
        val_next = val_reg;
        vld_next = vld_reg;
        if (ctrl.insert)
        begin
            if (prev_ins)
            begin
                val_next = prev_value;
                vld_next = prev_valid;
            end
            else if (ins)
            begin
                val_next = new_value;
                vld_next = 1'b1;
            end
        end
        else if (ctrl.shift_out)
        begin
            val_next = next_value;
            vld_next = next_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign value_q = val_reg;
    assign valid_q = vld_reg;

endmodule
`default_nettype wire
